@@ hdl/sfma_pkg.sv @@
// Shared types, codes and sizes for the spatial filter matrix apply block.
`default_nettype none
package sfma_pkg;

    // Table geometry. Channel indexes are four bits wide in the item format.
    localparam int MAX_INPUT_CHANNELS  = 16;
    localparam int MAX_OUTPUT_CHANNELS = 16;
    localparam int CH_W    = 4;
    localparam int CNT_W   = 5;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = 32;
    localparam int ACC_W   = 40;
    localparam int TADDR_W = 2 * CH_W;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_CHANNELS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_CHANNELS = 1'd1;
    localparam logic [CNT_W-1:0] CFG_CNT_RESET = 5'd16;

    // Operation codes of an input beat.
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;

    typedef struct packed {
        logic [1:0]              operation;
        logic [CH_W-1:0]         out_index;
        logic [CH_W-1:0]         in_index;
        logic signed [COEF_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [CH_W-1:0]         out_channel;
        logic signed [ACC_W-1:0] filtered;
        logic                    last;
        logic                    status;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_CLEAR,
        CMD_SAMPLE,
        CMD_ERROR
    } cmd_kind_t;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        cmd_kind_t                kind;
        logic [CH_W-1:0]          row;
        logic [CH_W-1:0]          col;
        logic signed [COEF_W-1:0] value;
        logic                     col_last;
        logic [CH_W-1:0]          nout_m1;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MAC,
        BK_DRAIN,
        BK_EMIT,
        BK_ERR
    } back_state_t;

endpackage
`default_nettype wire

@@ hdl/sfma_front.sv @@
// Front end: configuration registers, item classification and the inactive flag.
`default_nettype none
module sfma_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [sfma_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sfma_pkg::CNT_W-1:0]     cfg_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire sfma_pkg::in_item_t             s_data,
    input  wire logic                           fifo_full,
    output logic                                push,
    output sfma_pkg::cmd_t                      push_data
);
    import sfma_pkg::*;

    localparam logic [CNT_W-1:0] MAX_IN_CNT  = CNT_W'(MAX_INPUT_CHANNELS);
    localparam logic [CNT_W-1:0] MAX_OUT_CNT = CNT_W'(MAX_OUTPUT_CHANNELS);

    logic [CNT_W-1:0] in_ch_reg;
    logic [CNT_W-1:0] out_ch_reg;
    logic             inactive_reg;
    logic             inactive_next;
    logic [CH_W-1:0]  nin_m1;
    logic [CH_W-1:0]  nout_m1;
    logic             accept;
    logic [CNT_W-1:0] nin_tmp;
    logic [CNT_W-1:0] nout_tmp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_ch_reg  <= CFG_CNT_RESET;
            out_ch_reg <= CFG_CNT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_INPUT_CHANNELS:  in_ch_reg  <= cfg_data;
                CFG_OUTPUT_CHANNELS: out_ch_reg <= cfg_data;
            endcase
        end
    end

    // Counts are clamped to [1, max] and kept as count minus one.
    always_comb begin
        priority if (in_ch_reg == '0)        nin_tmp = CNT_W'(1);
        else if (in_ch_reg > MAX_IN_CNT)     nin_tmp = MAX_IN_CNT;
        else                                 nin_tmp = in_ch_reg;
        priority if (out_ch_reg == '0)       nout_tmp = CNT_W'(1);
        else if (out_ch_reg > MAX_OUT_CNT)   nout_tmp = MAX_OUT_CNT;
        else                                 nout_tmp = out_ch_reg;
        nin_m1  = CH_W'(nin_tmp - CNT_W'(1));
        nout_m1 = CH_W'(nout_tmp - CNT_W'(1));
    end

    assign s_ready = !fifo_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        push               = 1'b0;
        inactive_next      = inactive_reg;
        push_data.kind     = CMD_LOAD;
        push_data.row      = s_data.out_index;
        push_data.col      = s_data.in_index;
        push_data.value    = s_data.value;
        push_data.col_last = (s_data.in_index == nin_m1);
        push_data.nout_m1  = nout_m1;
        if (accept) begin
            unique case (s_data.operation)
                OP_LOAD: begin
                    push           = !inactive_reg;
                    push_data.kind = CMD_LOAD;
                end
                OP_CLEAR: begin
                    push           = !inactive_reg;
                    push_data.kind = CMD_CLEAR;
                end
                OP_SAMPLE: begin
                    push = 1'b1;
                    if (inactive_reg || (s_data.in_index > nin_m1)) begin
                        push_data.kind = CMD_ERROR;
                        inactive_next  = 1'b1;
                    end else begin
                        push_data.kind = CMD_SAMPLE;
                    end
                end
                default: begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inactive_reg <= 1'b0;
        end else begin
            inactive_reg <= inactive_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/sfma_cmd_fifo.sv @@
// Short command queue between the front end and the back end.
`default_nettype none
module sfma_cmd_fifo (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire sfma_pkg::cmd_t push_data,
    output logic                full,
    input  wire logic           pop,
    output sfma_pkg::cmd_t      pop_data,
    output logic                empty
);
    import sfma_pkg::*;

    cmd_t               entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + (FIFO_AW + 1)'(1);
                2'b01:   count_reg <= count_reg - (FIFO_AW + 1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ hdl/sfma_back.sv @@
// Back end: coefficient table, multiply-accumulate pipeline and result emission.
`default_nettype none
module sfma_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           fifo_empty,
    input  wire sfma_pkg::cmd_t cmd,
    output logic                pop,
    output logic                m_valid,
    input  wire logic           m_ready,
    output sfma_pkg::out_item_t m_data
);
    import sfma_pkg::*;

    localparam logic signed [ACC_W:0] ACC_MAX = (ACC_W + 1)'((64'sd1 <<< (ACC_W - 1)) - 1);
    localparam logic signed [ACC_W:0] ACC_MIN = -(ACC_W + 1)'(64'sd1 <<< (ACC_W - 1));

    logic signed [COEF_W-1:0] coef_mem [MAX_INPUT_CHANNELS * MAX_OUTPUT_CHANNELS];
    logic signed [ACC_W-1:0]  acc_reg  [MAX_OUTPUT_CHANNELS];

    back_state_t state_reg, state_next;
    logic [CH_W-1:0] idx_reg, idx_next;
    cmd_t            cur_reg;

    logic                     s1_valid_reg;
    logic [CH_W-1:0]          s1_idx_reg;
    logic signed [COEF_W-1:0] coef_rd_reg;
    logic                     s2_valid_reg;
    logic [CH_W-1:0]          s2_idx_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic                     m_valid_reg;
    out_item_t                m_data_reg;

    logic                     issue;
    logic                     mem_we;
    logic                     acc_clear;
    logic                     out_load;
    out_item_t                out_data;
    logic                     slot_free;
    logic [CH_W-1:0]          acc_rd_addr;
    logic signed [ACC_W-1:0]  acc_rd;
    logic signed [ACC_W:0]    acc_sum;
    logic signed [ACC_W-1:0]  acc_sat;

    assign slot_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        issue      = 1'b0;
        mem_we     = 1'b0;
        acc_clear  = 1'b0;
        out_load   = 1'b0;
        out_data.out_channel = idx_reg;
        out_data.filtered    = acc_rd;
        out_data.last        = (idx_reg == cur_reg.nout_m1);
        out_data.status      = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                if (!fifo_empty) begin
                    pop = 1'b1;
                    unique case (cmd.kind)
                        CMD_LOAD:   mem_we = 1'b1;
                        CMD_CLEAR:  acc_clear = 1'b1;
                        CMD_SAMPLE: begin
                            state_next = BK_MAC;
                            idx_next   = '0;
                        end
                        CMD_ERROR:  state_next = BK_ERR;
                    endcase
                end
            end
            BK_MAC: begin
                issue    = 1'b1;
                idx_next = idx_reg + CH_W'(1);
                if (idx_reg == cur_reg.nout_m1) begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN: begin
                idx_next = '0;
                if (!s1_valid_reg && !s2_valid_reg) begin
                    state_next = cur_reg.col_last ? BK_EMIT : BK_IDLE;
                end
            end
            BK_EMIT: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    idx_next = idx_reg + CH_W'(1);
                    if (idx_reg == cur_reg.nout_m1) begin
                        acc_clear  = 1'b1;
                        state_next = BK_IDLE;
                    end
                end
            end
            BK_ERR: begin
                out_data.out_channel = '0;
                out_data.filtered    = '0;
                out_data.last        = 1'b0;
                out_data.status      = 1'b1;
                if (slot_free) begin
                    out_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= cmd;
        end
    end

    // Coefficient table, one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            coef_mem[{cmd.row, cmd.col}] <= cmd.value;
        end
        coef_rd_reg <= coef_mem[{idx_reg, cur_reg.col}];
    end

    always_ff @(posedge aclk) begin
        s1_idx_reg <= idx_reg;
        s2_idx_reg <= s1_idx_reg;
        prod_reg   <= coef_rd_reg * cur_reg.value;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    assign acc_rd_addr = (state_reg == BK_EMIT) ? idx_reg : s2_idx_reg;
    assign acc_rd      = acc_reg[acc_rd_addr];

    always_comb begin
        acc_sum = (ACC_W + 1)'(acc_rd) + (ACC_W + 1)'(prod_reg);
        priority if (acc_sum > ACC_MAX)   acc_sat = ACC_MAX[ACC_W-1:0];
        else if (acc_sum < ACC_MIN)       acc_sat = ACC_MIN[ACC_W-1:0];
        else                              acc_sat = acc_sum[ACC_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || acc_clear) begin
            for (int i = 0; i < MAX_OUTPUT_CHANNELS; i++) begin
                acc_reg[i] <= '0;
            end
        end else if (s2_valid_reg) begin
            acc_reg[s2_idx_reg] <= acc_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= out_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

@@ hdl/spatial_filter_matrix_apply.sv @@
// Top level of the spatial filter matrix apply block.
//
// The input channel (s_valid, s_ready, s_data) carries one beat per item: a
// coefficient load, an accumulator clear or one sample of one input channel.
// The result channel (m_valid, m_ready, m_data) carries one beat per filtered
// output channel when a column completes, the final one flagged by last, or a
// status beat for a sample naming a channel outside the configured count and for
// every sample after it. The configuration port writes the input and output
// channel counts and must only be used while the block is idle.
// A front end classifies each accepted beat and places a command in a
// four-entry queue, so s_ready stays high until that queue fills; once a
// sample has failed, loads and clears are dropped rather than queued.
// The back end retires a load or a clear as it takes it from the queue. A
// sample is taken from the queue, the coefficient table is read once per
// output channel, then the back end waits while the multiplier and the
// saturating accumulator stages drain. A column-ending sample then emits
// nout beats, one per cycle while m_ready is high.
// When the receiver stalls, the output register holds its beat and the back
// end waits; the front end keeps filling the queue.
// Synchronous reset clears the accumulators, the error flag and the queue and
// sets both channel counts to 16; the coefficient table holds no reset value.
`default_nettype none
module spatial_filter_matrix_apply (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [sfma_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sfma_pkg::CNT_W-1:0]     cfg_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire sfma_pkg::in_item_t             s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output sfma_pkg::out_item_t                 m_data
);
    import sfma_pkg::*;

    // Commands travel from the classifier to the executor through the queue.
    logic push;
    cmd_t push_data;
    logic fifo_full;
    logic pop;
    cmd_t pop_data;
    logic fifo_empty;

    sfma_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .fifo_full (fifo_full),
        .push      (push),
        .push_data (push_data)
    );

    sfma_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (fifo_empty)
    );

    // The executor owns the coefficient table, the accumulators and the
    // output register.
    sfma_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_empty (fifo_empty),
        .cmd        (pop_data),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
`default_nettype wire
